// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define CLB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, kept live through reset.
`define CLB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/clb_pkg.sv =====
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and constants of the clip rectangle list builder.
// ----------------------------------------------------------------------------
package clb_pkg;

  localparam int MAX_RECTS = 64;
  localparam int IDX_W     = $clog2(MAX_RECTS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int COORD_W   = 16;
  localparam int SIZE_W    = 15;
  localparam int ARITH_W   = COORD_W + 2;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic        [SIZE_W-1:0]  h;
    logic        [SIZE_W-1:0]  w;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

endpackage

// ===== rtl/clb_ram.sv =====
// ----------------------------------------------------------------------------
// clb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/clip_rect_list_builder.sv =====
// ----------------------------------------------------------------------------
// clip_rect_list_builder
// Keeps a list of non-overlapping clip rectangles in one RAM.
// ----------------------------------------------------------------------------
// One word in, one word out. An add walks the list through the single RAM
// read port: each entry is read and checked in turn, and on a hit the entries
// behind it are moved down one at a time to close the gap, the hit is cut into
// its left, top, right and bottom pieces, then the scan restarts from entry 0.
// An add on an empty list goes straight to the append. A new word is taken while the
// previous result still waits on the output.
module clip_rect_list_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rect_x[15:0], rect_y[31:16], rect_w[46:32], rect_h[61:47], read_index[67:62]
  input  logic [clb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [clb_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_x[15:0], out_y[31:16], out_w[46:32], out_h[61:47],
  // entry_count[68:62], overflow[69], index_valid[70]
  output logic [clb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import clb_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SCAN_RD   = 4'd1;
  localparam logic [3:0] ST_SCAN_CHK  = 4'd2;
  localparam logic [3:0] ST_SHIFT_RD  = 4'd3;
  localparam logic [3:0] ST_SHIFT_WR  = 4'd4;
  localparam logic [3:0] ST_CUT_L     = 4'd5;
  localparam logic [3:0] ST_CUT_T     = 4'd6;
  localparam logic [3:0] ST_CUT_R     = 4'd7;
  localparam logic [3:0] ST_CUT_B     = 4'd8;
  localparam logic [3:0] ST_APPEND    = 4'd9;
  localparam logic [3:0] ST_READ_RD   = 4'd10;
  localparam logic [3:0] ST_READ_WAIT = 4'd11;
  localparam logic [3:0] ST_FINISH    = 4'd12;

  localparam logic signed [ARITH_W-1:0] CoordHi = ARITH_W'((1 <<< (COORD_W-1)) - 1);
  localparam logic signed [ARITH_W-1:0] One     = ARITH_W'(1);

  logic [3:0]     state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic           ovf_q, ovf_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  rect_t          c_q, c_d;
  rect_t          t_q, t_d;
  rect_t          res_q, res_d;
  logic           iv_q, iv_d;
  logic           m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  rect_t            ram_wdata, ram_rdata;

  logic                      app_en;
  logic signed [ARITH_W-1:0] app_x, app_y, app_w, app_h;

  logic signed [ARITH_W-1:0] tx, ty, tw, th, tr, tb;
  logic signed [ARITH_W-1:0] cx, cy, cr, cb;
  logic signed [ARITH_W-1:0] sx, sy, sr, sb;
  logic signed [ARITH_W-1:0] in_x, in_y, in_r, in_b;
  logic                      hit;

  clb_ram #(.WIDTH(RECT_W), .DEPTH(MAX_RECTS)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    tx = ARITH_W'(t_q.x);
    ty = ARITH_W'(t_q.y);
    tw = ARITH_W'({1'b0, t_q.w});
    th = ARITH_W'({1'b0, t_q.h});
    tr = tx + tw - One;
    tb = ty + th - One;
    cx = ARITH_W'(c_q.x);
    cy = ARITH_W'(c_q.y);
    cr = cx + ARITH_W'({1'b0, c_q.w}) - One;
    cb = cy + ARITH_W'({1'b0, c_q.h}) - One;
    sx = ARITH_W'(ram_rdata.x);
    sy = ARITH_W'(ram_rdata.y);
    sr = sx + ARITH_W'({1'b0, ram_rdata.w}) - One;
    sb = sy + ARITH_W'({1'b0, ram_rdata.h}) - One;
    hit = (sx <= cr) && (cx <= sr) && (sy <= cb) && (cy <= sb);

    in_x = ARITH_W'($signed(s_axis_tdata[15:0]));
    in_y = ARITH_W'($signed(s_axis_tdata[31:16]));
    in_r = in_x + ARITH_W'({1'b0, s_axis_tdata[46:32]}) - One;
    in_b = in_y + ARITH_W'({1'b0, s_axis_tdata[61:47]}) - One;
    if (in_r > CoordHi) begin
      in_r = CoordHi;
    end
    if (in_b > CoordHi) begin
      in_b = CoordHi;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    idx_d     = idx_q;
    c_d       = c_q;
    t_d       = t_q;
    res_d     = res_q;
    iv_d      = iv_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[IDX_W-1:0];
    ram_wdata = '0;
    ram_raddr = i_q[IDX_W-1:0];
    app_en    = 1'b0;
    app_x     = '0;
    app_y     = '0;
    app_w     = '0;
    app_h     = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_d = '0;
          iv_d  = 1'b0;
          idx_d = s_axis_tdata[67:62];
          c_d.x = s_axis_tdata[15:0];
          c_d.y = s_axis_tdata[31:16];
          c_d.w = SIZE_W'(in_r - in_x + One);
          c_d.h = SIZE_W'(in_b - in_y + One);
          i_d   = '0;
          case (op_e'(s_axis_tuser))
            OP_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
              state_d = ST_FINISH;
            end
            OP_ADD: begin
              if (s_axis_tdata[46:32] == '0 || s_axis_tdata[61:47] == '0) begin
                state_d = ST_FINISH;
              end else begin
                state_d = ST_SCAN_RD;
              end
            end
            OP_READ:  state_d = ST_READ_RD;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (i_q < count_q) begin
          state_d = ST_SCAN_CHK;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_SCAN_CHK: begin
        if (hit) begin
          t_d     = ram_rdata;
          j_d     = i_q;
          state_d = ST_SHIFT_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        // close the gap left by the removed entry, one entry per pass
        ram_raddr = IDX_W'(j_q + 1'b1);
        if (j_q + 1'b1 < count_q) begin
          state_d = ST_SHIFT_WR;
        end else begin
          count_d = count_q - 1'b1;
          state_d = ST_CUT_L;
        end
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IDX_W-1:0];
        ram_wdata = ram_rdata;
        j_d       = j_q + 1'b1;
        state_d   = ST_SHIFT_RD;
      end
      ST_CUT_L: begin
        if (cx >= tx && cx <= tr) begin
          app_en = 1'b1;
          app_x  = tx;
          app_y  = ty;
          app_w  = cx - tx;
          app_h  = th;
          t_d.w  = SIZE_W'(tw - (cx - tx));
          t_d.x  = c_q.x;
        end
        state_d = ST_CUT_T;
      end
      ST_CUT_T: begin
        if (cy >= ty && cy <= tb) begin
          app_en = 1'b1;
          app_x  = tx;
          app_y  = ty;
          app_w  = tw;
          app_h  = cy - ty;
          t_d.h  = SIZE_W'(th - (cy - ty));
          t_d.y  = c_q.y;
        end
        state_d = ST_CUT_R;
      end
      ST_CUT_R: begin
        if (cr >= tx && cr <= tr) begin
          app_en = 1'b1;
          app_x  = cr + One;
          app_y  = ty;
          app_w  = tr - cr;
          app_h  = th;
          t_d.w  = SIZE_W'(tw - (tr - cr));
        end
        state_d = ST_CUT_B;
      end
      ST_CUT_B: begin
        if (cb >= ty && cb <= tb) begin
          app_en = 1'b1;
          app_x  = tx;
          app_y  = cb + One;
          app_w  = tw;
          app_h  = tb - cb;
        end
        i_d     = '0;
        state_d = ST_SCAN_RD;
      end
      ST_APPEND: begin
        app_en  = 1'b1;
        app_x   = cx;
        app_y   = cy;
        app_w   = ARITH_W'({1'b0, c_q.w});
        app_h   = ARITH_W'({1'b0, c_q.h});
        state_d = ST_FINISH;
      end
      ST_READ_RD: begin
        ram_raddr = idx_q;
        if (CNT_W'(idx_q) < count_q) begin
          state_d = ST_READ_WAIT;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_READ_WAIT: begin
        res_d   = ram_rdata;
        iv_d    = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, iv_q, ovf_q, count_q, res_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // drop empty pieces; drop and flag on a full list
    if (app_en && app_w > 0 && app_h > 0) begin
      if (count_q >= CNT_W'(MAX_RECTS)) begin
        ovf_d = 1'b1;
      end else begin
        ram_we      = 1'b1;
        ram_waddr   = count_q[IDX_W-1:0];
        ram_wdata.x = COORD_W'(app_x);
        ram_wdata.y = COORD_W'(app_y);
        ram_wdata.w = SIZE_W'(app_w);
        ram_wdata.h = SIZE_W'(app_h);
        count_d     = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    idx_q    <= idx_d;
    c_q      <= c_d;
    t_q      <= t_d;
    res_q    <= res_d;
    iv_q     <= iv_d;
    m_data_q <= m_data_d;
  end

endmodule

// ===== rtl/clb_checker.sv =====
// ----------------------------------------------------------------------------
// clb_checker
// Port-level checks of the clip rectangle list builder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [clb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [clb_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [clb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import clb_pkg::*;

  logic       in_word;
  logic [6:0] out_count;

  assign in_word   = s_axis_tvalid && s_axis_tready && (s_axis_tuser != '1);
  assign out_count = m_axis_tdata[68:62];

  `CLB_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
  `CLB_ASSERT(a_count_range, m_axis_tvalid |-> out_count <= 7'(MAX_RECTS), "entry count above list size")
  `CLB_ASSERT(a_invalid_zero, m_axis_tvalid && !m_axis_tdata[70] |-> m_axis_tdata[61:0] == '0, "rectangle fields set without a valid read")
  `CLB_ASSERT(a_valid_nonempty, m_axis_tvalid && m_axis_tdata[70] |-> out_count != '0 && m_axis_tdata[46:32] != '0, "valid read from an empty list or of an empty entry")
  `CLB_ASSERT(a_no_busy_accept, in_word |=> !s_axis_tready, "new word taken while still busy")

endmodule

bind clip_rect_list_builder clb_checker u_clb_checker (.*);

// ===== dv/clip_rect_list_builder_tb.sv =====
// ----------------------------------------------------------------------------
// clip_rect_list_builder_tb
// Drives clear, add and read words into the clip list builder. It rebuilds the
// rectangle list on the side, predicts every output word and compares the two.
// ----------------------------------------------------------------------------
module clip_rect_list_builder_tb;
  import clb_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [5:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [6:0]  cnt;
    logic        ovf;
    logic        vld;
  } resp_t;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } box_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  cmd_t  pending_q[$];
  resp_t expected_q[$];
  box_t  clip_list[$];
  logic  clip_ovf;
  int    fail_cnt;
  int    idle_cnt;
  int    src_idle_pct;
  int    dst_idle_pct;
  int    hold_off;
  int    words_in;
  int    words_out;
  int    reads_hit;
  int    ovf_seen;
  bit    stim_done;

  clip_rect_list_builder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clip_append(int x, int y, int w, int h);
    box_t b;
    if (w <= 0 || h <= 0) return;
    if (clip_list.size() >= MAX_RECTS) begin
      clip_ovf = 1'b1;
      return;
    end
    b.x = x; b.y = y; b.w = w; b.h = h;
    clip_list.push_back(b);
  endfunction

  function automatic bit boxes_touch(box_t a, box_t b);
    return a.x <= b.x + b.w - 1 && b.x <= a.x + a.w - 1 &&
           a.y <= b.y + b.h - 1 && b.y <= a.y + a.h - 1;
  endfunction

  // Split t around c: left, top, right, bottom pieces in that order.
  function automatic void split_around(box_t t, box_t c);
    int cr;
    int cb;
    int tr;
    int tb;
    cr = c.x + c.w - 1;
    cb = c.y + c.h - 1;
    tr = t.x + t.w - 1;
    tb = t.y + t.h - 1;
    if (c.x >= t.x && c.x <= tr) begin
      clip_append(t.x, t.y, c.x - t.x, t.h);
      t.w -= c.x - t.x;
      t.x = c.x;
    end
    if (c.y >= t.y && c.y <= tb) begin
      clip_append(t.x, t.y, t.w, c.y - t.y);
      t.h -= c.y - t.y;
      t.y = c.y;
    end
    tr = t.x + t.w - 1;
    tb = t.y + t.h - 1;
    if (cr >= t.x && cr <= tr) begin
      clip_append(cr + 1, t.y, tr - cr, t.h);
      t.w -= tr - cr;
    end
    if (cb >= t.y && cb <= tb) begin
      clip_append(t.x, cb + 1, t.w, tb - cb);
    end
  endfunction

  function automatic void clip_add(int x, int y, int w, int h);
    box_t nr;
    box_t t;
    int   r;
    int   b;
    int   i;
    if (w <= 0 || h <= 0) return;
    r = x + w - 1;
    b = y + h - 1;
    if (x < -32768) x = -32768;
    if (y < -32768) y = -32768;
    if (r > 32767) r = 32767;
    if (b > 32767) b = 32767;
    if (r < x || b < y) return;
    nr.x = x; nr.y = y; nr.w = r - x + 1; nr.h = b - y + 1;
    i = 0;
    while (i < clip_list.size()) begin
      if (!boxes_touch(clip_list[i], nr)) begin
        i++;
      end else begin
        t = clip_list[i];
        clip_list.delete(i);
        split_around(t, nr);
        i = 0;
      end
    end
    clip_append(nr.x, nr.y, nr.w, nr.h);
  endfunction

  function automatic resp_t predict_word(cmd_t c);
    resp_t r;
    r = '0;
    case (op_e'(c.op))
      OP_CLEAR: begin
        clip_list.delete();
        clip_ovf = 1'b0;
      end
      OP_ADD: begin
        clip_add($signed(c.x), $signed(c.y), int'(c.w), int'(c.h));
      end
      OP_READ: begin
        if (c.idx < clip_list.size()) begin
          r.vld = 1'b1;
          r.x = clip_list[c.idx].x[15:0];
          r.y = clip_list[c.idx].y[15:0];
          r.w = clip_list[c.idx].w[14:0];
          r.h = clip_list[c.idx].h[14:0];
        end
      end
      default: ;
    endcase
    r.cnt = 7'(clip_list.size());
    r.ovf = clip_ovf;
    return r;
  endfunction

  function automatic cmd_t mk_cmd(op_e op, int x, int y, int w, int h, int idx);
    cmd_t c;
    c.op = op; c.x = x[15:0]; c.y = y[15:0]; c.w = w[14:0]; c.h = h[14:0];
    c.idx = idx[5:0];
    return c;
  endfunction

  // Mostly small boxes in a small window so they overlap and split often.
  function automatic cmd_t rand_cmd(bit grid);
    cmd_t c;
    int   sel;
    c = '0;
    c.idx = 6'($urandom_range(0, 63));
    sel = $urandom_range(0, 99);
    if (sel < 8) c.op = OP_CLEAR;
    else if (sel < 55) c.op = OP_ADD;
    else if (sel < 97) c.op = OP_READ;
    else c.op = OP_NONE;
    if (grid) begin
      c.x = 16'($urandom_range(0, 60) - 20);
      c.y = 16'($urandom_range(0, 60) - 20);
      c.w = 15'($urandom_range(0, 24));
      c.h = 15'($urandom_range(0, 24));
      if (c.op == OP_READ && $urandom_range(0, 3) != 0)
        c.idx = 6'($urandom_range(0, 20));
    end else begin
      c.x = 16'($urandom);
      c.y = 16'($urandom);
      c.w = 15'($urandom);
      c.h = 15'($urandom);
    end
    return c;
  endfunction

  initial begin
    int n;
    rst_ni = 1'b0;
    fail_cnt = 0;
    stim_done = 1'b0;
    clip_ovf = 1'b0;
    src_idle_pct = 25;
    dst_idle_pct = 72;
    hold_off = 0;
    // Directed: extremes, every opcode, empty and clipped boxes, splits.
    pending_q.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_cmd(OP_ADD, -32768, -32768, 32767, 32767, 0));
    pending_q.push_back(mk_cmd(OP_ADD, 32767, 32767, 32767, 32767, 0));
    pending_q.push_back(mk_cmd(OP_ADD, 5, 5, 0, 9, 0));
    pending_q.push_back(mk_cmd(OP_ADD, 5, 5, 9, 0, 0));
    pending_q.push_back(mk_cmd(OP_ADD, -100, -100, 50, 50, 0));
    pending_q.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 63));
    pending_q.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_cmd(OP_ADD, 0, 0, 30, 30, 0));
    pending_q.push_back(mk_cmd(OP_ADD, 10, 10, 10, 10, 0));
    pending_q.push_back(mk_cmd(OP_NONE, -1, -1, 32767, 32767, 63));
    for (int i = 0; i < 5; i++)
      pending_q.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, i));
    // Fill past the limit with disjoint boxes to hit overflow.
    for (int i = 0; i < 66; i++)
      pending_q.push_back(mk_cmd(OP_ADD, 100 + 3 * i, 100, 2, 2, 0));
    pending_q.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 63));
    pending_q.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < 1900; i++)
      pending_q.push_back(rand_cmd($urandom_range(0, 9) != 0));
    n = pending_q.size();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (words_in > n / 3);
    src_idle_pct = 72;
    dst_idle_pct = 25;
    hold_off = 400;
    wait (words_in > 2 * n / 3);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    stim_done = 1'b1;
  end

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      words_in      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        c = pending_q.pop_front();
        expected_q.push_back(predict_word(c));
        words_in <= words_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          c = pending_q[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= c.op;
          s_axis_tdata  <= {4'b0, c.idx, c.h, c.w, c.y, c.x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    resp_t e;
    resp_t a;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      words_out <= 0;
      reads_hit <= 0;
      ovf_seen  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out <= words_out + 1;
        a.x = m_axis_tdata[15:0];
        a.y = m_axis_tdata[31:16];
        a.w = m_axis_tdata[46:32];
        a.h = m_axis_tdata[61:47];
        a.cnt = m_axis_tdata[68:62];
        a.ovf = m_axis_tdata[69];
        a.vld = m_axis_tdata[70];
        if (expected_q.size() == 0) begin
          $error("output word with nothing expected");
          fail_cnt++;
        end else begin
          e = expected_q.pop_front();
          if (a.vld) reads_hit <= reads_hit + 1;
          if (a.ovf) ovf_seen <= ovf_seen + 1;
          if (a.x !== e.x) begin
            $error("out_x exp %0d got %0d", $signed(e.x), $signed(a.x)); fail_cnt++;
          end
          if (a.y !== e.y) begin
            $error("out_y exp %0d got %0d", $signed(e.y), $signed(a.y)); fail_cnt++;
          end
          if (a.w !== e.w) begin
            $error("out_w exp %0d got %0d", e.w, a.w); fail_cnt++;
          end
          if (a.h !== e.h) begin
            $error("out_h exp %0d got %0d", e.h, a.h); fail_cnt++;
          end
          if (a.cnt !== e.cnt) begin
            $error("entry_count exp %0d got %0d", e.cnt, a.cnt); fail_cnt++;
          end
          if (a.ovf !== e.ovf) begin
            $error("overflow exp %0d got %0d", e.ovf, a.ovf); fail_cnt++;
          end
          if (a.vld !== e.vld) begin
            $error("index_valid exp %0d got %0d", e.vld, a.vld); fail_cnt++;
          end
        end
      end
      // Long hold-off lets the block back up and stall its input.
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WATCHDOG_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_q.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("%0d words in, %0d words out, %0d reads hit a stored box, %0d with overflow",
             words_in, words_out, reads_hit, ovf_seen);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
